>>> src/rmd320_pkg.sv
// Package for the RIPEMD-320 hash block: round constants, schedules and helpers.
// Used by rmd320_core, ripemd320_hash_top and ripemd320_digest_checker; depends on nothing else.
package rmd320_pkg;
	localparam logic [31:0] IV [10] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
		32'h10325476, 32'hC3D2E1F0, 32'h76543210, 32'hFEDCBA98, 32'h89ABCDEF,
		32'h01234567, 32'h3C2D1E0F};
	localparam logic [31:0] KL [5] = '{32'h0, 32'h5A827999, 32'h6ED9EBA1,
		32'h8F1BBCDC, 32'hA953FD4E};
	localparam logic [31:0] KR [5] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
		32'h7A6D76E9, 32'h0};
	localparam logic [3:0] WL [80] = '{
		0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
		7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
		3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
		1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
		4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
	localparam logic [3:0] WR [80] = '{
		5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
		6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
		15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
		8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
		12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
	localparam logic [3:0] SL [80] = '{
		11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
		7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
		11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
		11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
		9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
	localparam logic [3:0] SR [80] = '{
		8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
		9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
		9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
		15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
		8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};

	typedef logic [31:0] word_t;

	function automatic word_t rotl(input word_t x, input logic [3:0] s);
		logic [63:0] d;
		d = {x, x} << s;
		return d[63:32];
	endfunction

	function automatic word_t rotl10(input word_t x);
		return {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bfn(input logic [2:0] j, input word_t x, input word_t y,
		input word_t z);
		word_t r;
		unique case (j)
			3'd0: r = x ^ y ^ z;
			3'd1: r = (x & y) | (~x & z);
			3'd2: r = (x | ~y) ^ z;
			3'd3: r = (x & z) | (y & ~z);
			default: r = x ^ (y | ~z);
		endcase
		return r;
	endfunction
endpackage

>>> src/rmd320_core.sv
// Compression core: 80 round pairs, one pair a cycle, reading the block buffer memory.
// Depends on rmd320_pkg; the buffer and chaining values sit in the top level.
module rmd320_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rmd320_pkg::word_t    cv [10],
	input  rmd320_pkg::word_t    wl_data,
	input  rmd320_pkg::word_t    wr_data,
	output logic [6:0]           rnd,
	output logic                 busy,
	output logic                 done,
	output rmd320_pkg::word_t    res [10]
);
	import rmd320_pkg::*;

	// Memory reads issue in the cycle before their round, so round rnd uses data read for rnd.
	word_t l_q [5];
	word_t r_q [5];
	logic [6:0] rnd_q;
	logic busy_q, run_q, done_q;
	logic [2:0] g;
	word_t tl, tr;
	word_t nl [5];
	word_t nr [5];
	word_t sl;

	assign rnd = rnd_q;
	assign busy = busy_q;
	assign done = done_q;
	assign g = rnd_q[6:4];

	always_comb begin
		tl = rotl(l_q[0] + bfn(g, l_q[1], l_q[2], l_q[3]) + wl_data + KL[g],
			SL[rnd_q]) + l_q[4];
		tr = rotl(r_q[0] + bfn(3'd4 - g, r_q[1], r_q[2], r_q[3]) + wr_data + KR[g],
			SR[rnd_q]) + r_q[4];
		nl = '{l_q[4], tl, l_q[1], rotl10(l_q[2]), l_q[3]};
		nr = '{r_q[4], tr, r_q[1], rotl10(r_q[2]), r_q[3]};
		if (rnd_q[3:0] == 4'hF) begin
			unique case (g)
				3'd0: begin sl = nl[1]; nl[1] = nr[1]; nr[1] = sl; end
				3'd1: begin sl = nl[3]; nl[3] = nr[3]; nr[3] = sl; end
				3'd2: begin sl = nl[0]; nl[0] = nr[0]; nr[0] = sl; end
				3'd3: begin sl = nl[2]; nl[2] = nr[2]; nr[2] = sl; end
				default: begin sl = nl[4]; nl[4] = nr[4]; nr[4] = sl; end
			endcase
		end else begin
			sl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			run_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				run_q <= 1'b0;
				rnd_q <= '0;
			end else if (busy_q && !run_q) begin
				run_q <= 1'b1;
			end else if (run_q) begin
				if (rnd_q == 7'd79) begin
					run_q <= 1'b0;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int p = 0; p < 5; p++) begin
				l_q[p] <= cv[p];
				r_q[p] <= cv[5 + p];
			end
		end else if (run_q) begin
			l_q <= nl;
			r_q <= nr;
		end
	end

	for (genvar p = 0; p < 5; p++) begin : g_res
		assign res[p] = cv[p] + l_q[p];
		assign res[5 + p] = cv[5 + p] + r_q[p];
	end

	a_done: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("done while busy");
	a_rnd: assert property (@(posedge clk) disable iff (!arst_n) rnd_q <= 7'd79)
		else $error("round out of range");
	a_start: assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("start did not raise busy");
endmodule

>>> src/ripemd320_hash_top.sv
// RIPEMD-320 hash engine top level: input stream, byte packing, padding, digest output.
// Depends on rmd320_pkg and rmd320_core.
//
// Usage: message words enter on s_axis (tdata = data_word[31:0], valid_bytes[34:32],
// zero fill; tlast = last). Bytes are packed into a 16-word block buffer memory,
// one byte a cycle while no block is compressing; a beat is accepted and then its
// bytes are packed. Each full 64-byte block then holds the input while the buffer
// read is primed, the 80 rounds run and the chaining values are folded.
// On a last beat the engine pads (0x80, zeros, 64-bit bit length) one byte a cycle
// while no block compresses, compresses once or twice and then presents ten digest
// beats on m_axis (tdata = digest_word[31:0], word_index[35:32], zero fill;
// tlast = last_word). A stalled receiver holds the current digest beat; no new
// input is taken until all ten have left. Reset loads the initial chaining values
// and clears counts.
// Input beats are taken only when the engine is idle between words.
module ripemd320_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // data_word[31:0], valid_bytes[34:32]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[35:32]
	output logic        m_axis_tlast
);
	import rmd320_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DATA = 3'd1;
	localparam logic [2:0] ST_PAD  = 3'd2;
	localparam logic [2:0] ST_LEN  = 3'd3;
	localparam logic [2:0] ST_COMP = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	word_t buf_mem [16];
	word_t rl_q, rr_q;
	word_t cv_q [10];
	word_t res [10];
	logic [60:0] cnt_q;
	logic [5:0] fill_q;
	logic [31:0] data_q;
	logic [2:0] nb_q;
	logic last_q, fin_q;
	logic [3:0] oidx_q;
	logic [63:0] bits_q;
	logic [6:0] rnd;
	logic busy, done, start;
	logic [7:0] byte_in;
	logic put;
	logic [2:0] ret_q;
	logic [3:0] ra_l, ra_r;
	logic prime_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {4'd0, oidx_q, cv_q[oidx_q]};
	assign m_axis_tlast = (oidx_q == 4'd9);

	always_comb begin
		put = 1'b0;
		byte_in = 8'h00;
		unique case (state_q)
			ST_DATA: begin put = (nb_q != 3'd0); byte_in = data_q[7:0]; end
			ST_PAD: begin put = 1'b1; byte_in = fin_q ? 8'h00 : 8'h80; end
			ST_LEN: begin put = 1'b1; byte_in = bits_q[7:0]; end
			default: ;
		endcase
	end

	assign start = put && (fill_q == 6'd63);
	// Round 0 address during the priming cycle, then one round ahead.
	assign ra_l = (!busy || prime_q || rnd == 7'd79) ? WL[0] : WL[rnd + 7'd1];
	assign ra_r = (!busy || prime_q || rnd == 7'd79) ? WR[0] : WR[rnd + 7'd1];

	always_ff @(posedge clk) begin
		if (put) begin
			if (fill_q[1:0] == 2'd0) buf_mem[fill_q[5:2]] <= {24'd0, byte_in};
			else buf_mem[fill_q[5:2]][8*fill_q[1:0] +: 8] <= byte_in;
		end
		rl_q <= buf_mem[ra_l];
		rr_q <= buf_mem[ra_r];
	end

	rmd320_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .cv(cv_q),
		.wl_data(rl_q), .wr_data(rr_q), .rnd(rnd), .busy(busy), .done(done), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cv_q <= IV;
			cnt_q <= '0;
			fill_q <= '0;
			oidx_q <= '0;
			ret_q <= ST_IDLE;
			prime_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			prime_q <= start;
			if (put) fill_q <= fill_q + 6'd1;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) state_q <= ST_DATA;
				ST_DATA: begin
					if (nb_q != 3'd0) cnt_q <= cnt_q + 61'd1;
					if (start) begin
						state_q <= ST_COMP;
						ret_q <= (nb_q > 3'd1 || last_q) ? ST_DATA : ST_IDLE;
					end else if (nb_q <= 3'd1) begin
						state_q <= last_q ? ST_PAD : ST_IDLE;
					end
				end
				ST_PAD: begin
					fin_q <= 1'b1;
					if (start) begin
						state_q <= ST_COMP;
						ret_q <= ST_PAD;
					end else if (fill_q == 6'd55) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (start) begin
						state_q <= ST_COMP;
						ret_q <= ST_OUT;
					end
				end
				ST_COMP: if (done) begin
					cv_q <= res;
					if (ret_q == ST_DATA && nb_q == 3'd0) state_q <= last_q ? ST_PAD
						: ST_IDLE;
					else state_q <= ret_q;
					if (ret_q == ST_OUT) oidx_q <= '0;
				end
				ST_OUT: if (m_axis_tready) begin
					if (oidx_q == 4'd9) begin
						oidx_q <= '0;
						state_q <= ST_IDLE;
						cv_q <= IV;
						cnt_q <= '0;
						fill_q <= '0;
						fin_q <= 1'b0;
					end else begin
						oidx_q <= oidx_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			data_q <= s_axis_tdata[31:0];
			nb_q <= (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
			last_q <= s_axis_tlast;
		end else if (state_q == ST_DATA && nb_q != 3'd0) begin
			data_q <= {8'd0, data_q[31:8]};
			nb_q <= nb_q - 3'd1;
		end
		if (state_q == ST_PAD && fill_q == 6'd55 && !start) bits_q <= {cnt_q, 3'd0};
		else if (state_q == ST_LEN) bits_q <= {8'd0, bits_q[63:8]};
	end

	a_out_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> oidx_q <= 4'd9) else $error("digest index out of range");
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
	a_comp: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == ST_COMP) else $error("block start lost");
endmodule

>>> tb/ripemd320_digest_checker.sv
// Checker for the RIPEMD-320 hash block: watches both stream channels, predicts the digest beats
// and compares them field by field. Depends on rmd320_pkg for the round tables.
`timescale 1ns / 100ps
module ripemd320_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending,
	output int          messages_done,
	output int          words_in
);
	import rmd320_pkg::*;

	localparam int SWAP_AT [5] = '{1, 3, 0, 2, 4};

	typedef struct packed {
		logic [31:0] word;
		logic [3:0]  index;
		logic        final_word;
	} digest_beat_t;

	logic [31:0]  chain [10];
	logic [31:0]  blk [16];
	logic [60:0]  msg_bytes;
	logic [5:0]   fill;
	digest_beat_t digest_q [$];

	function automatic logic [31:0] rol(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic logic [31:0] mix(input int j, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z);
		case (j)
			0: return x ^ y ^ z;
			1: return (x & y) | (~x & z);
			2: return (x | ~y) ^ z;
			3: return (x & z) | (y & ~z);
			default: return x ^ (y | ~z);
		endcase
	endfunction

	task automatic compress_block();
		logic [31:0] l [5];
		logic [31:0] r [5];
		logic [31:0] t;
		int g;
		int p;
		for (int k = 0; k < 5; k++) begin
			l[k] = chain[k];
			r[k] = chain[5 + k];
		end
		for (int i = 0; i < 80; i++) begin
			g = i / 16;
			t = rol(l[0] + mix(g, l[1], l[2], l[3]) + blk[WL[i]] + KL[g], SL[i]) + l[4];
			l[0] = l[4]; l[4] = l[3]; l[3] = rol(l[2], 10); l[2] = l[1]; l[1] = t;
			t = rol(r[0] + mix(4 - g, r[1], r[2], r[3]) + blk[WR[i]] + KR[g], SR[i]) + r[4];
			r[0] = r[4]; r[4] = r[3]; r[3] = rol(r[2], 10); r[2] = r[1]; r[1] = t;
			if (i % 16 == 15) begin
				p = SWAP_AT[g];
				t = l[p]; l[p] = r[p]; r[p] = t;
			end
		end
		for (int k = 0; k < 5; k++) begin
			chain[k] = chain[k] + l[k];
			chain[5 + k] = chain[5 + k] + r[k];
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		if (fill[1:0] == 2'd0)
			blk[fill[5:2]] = {24'd0, b};
		else
			blk[fill[5:2]] = blk[fill[5:2]] | ({24'd0, b} << (8 * fill[1:0]));
		fill = fill + 6'd1;
		if (fill == 6'd0)
			compress_block();
	endtask

	task automatic absorb_word(input logic [31:0] d, input logic [2:0] n, input logic fin);
		int cnt;
		logic [63:0] bits;
		digest_beat_t b;
		cnt = (n > 3'd4) ? 4 : int'(n);
		for (int k = 0; k < cnt; k++) begin
			push_byte(d[8 * k +: 8]);
			msg_bytes = msg_bytes + 61'd1;
		end
		if (fin) begin
			bits = {msg_bytes, 3'b000};
			push_byte(8'h80);
			while (fill != 6'd56)
				push_byte(8'h00);
			for (int k = 0; k < 8; k++)
				push_byte(bits[8 * k +: 8]);
			for (int k = 0; k < 10; k++) begin
				b.word = chain[k];
				b.index = k[3:0];
				b.final_word = (k == 9);
				digest_q.push_back(b);
			end
			for (int k = 0; k < 10; k++)
				chain[k] = IV[k];
			msg_bytes = '0;
			fill = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_beat_t e;
		if (!arst_n) begin
			for (int k = 0; k < 10; k++)
				chain[k] = IV[k];
			for (int k = 0; k < 16; k++)
				blk[k] = '0;
			msg_bytes = '0;
			fill = '0;
			digest_q.delete();
			fail_count = 0;
			messages_done = 0;
			words_in = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					$error("digest beat with nothing expected: tdata %h", m_axis_tdata);
					fail_count++;
				end else begin
					e = digest_q.pop_front();
					if (m_axis_tdata[31:0] !== e.word) begin
						$error("digest_word expected %h actual %h", e.word, m_axis_tdata[31:0]);
						fail_count++;
					end
					if (m_axis_tdata[35:32] !== e.index) begin
						$error("word_index expected %0d actual %0d", e.index,
							m_axis_tdata[35:32]);
						fail_count++;
					end
					if (m_axis_tlast !== e.final_word) begin
						$error("last_word expected %b actual %b", e.final_word, m_axis_tlast);
						fail_count++;
					end
					if (e.final_word)
						messages_done++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
				words_in++;
			end
		end
		pending = digest_q.size();
	end
endmodule

>>> tb/ripemd320_hash_top_test.sv
// Top of the RIPEMD-320 hash testbench: clock, reset, message stimulus and receiver stalls.
// Depends on ripemd320_hash_top and ripemd320_digest_checker.
`timescale 1ns / 100ps
module ripemd320_hash_top_test;
	localparam int CYCLE_LIMIT = 400000;
	localparam int WORD_TARGET = 160;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	int fail_count;
	int pending;
	int messages_done;
	int words_in;
	int cycles = 0;
	int burst_left = 0;
	int hold_left = 0;
	int sent = 0;

	ripemd320_hash_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	ripemd320_digest_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count), .pending(pending),
		.messages_done(messages_done), .words_in(words_in)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver rotates through three stall patterns and once holds off for a long spell.
	always @(negedge clk) begin
		if (cycles == 1500)
			hold_left = 600;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case ((cycles / 97) % 3)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_word(input logic [31:0] d, input logic [2:0] n, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tdata <= {5'd0, n, d};
		s_axis_tlast <= fin;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic send_message(input int nwords, input bit odd_words);
		logic [2:0] n;
		for (int k = 0; k < nwords; k++) begin
			n = 3'd4;
			if (k == nwords - 1 || (odd_words && $urandom_range(0, 9) == 0))
				n = 3'($urandom_range(0, 7));
			send_word($urandom, n, k == nwords - 1);
		end
	endtask

	initial begin
		int pick;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
		send_word(32'h0063_6261, 3'd3, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		send_word(32'h0000_0000, 3'd4, 1'b1);
		send_word(32'hA5A5_A5A5, 3'd7, 1'b1);
		send_word(32'h5A5A_5A5A, 3'd5, 1'b1);
		send_word(32'h1234_5678, 3'd1, 1'b0);
		send_word(32'h9ABC_DEF0, 3'd2, 1'b0);
		send_word(32'hFEDC_BA98, 3'd3, 1'b0);
		send_word(32'h7654_3210, 3'd0, 1'b1);
		for (int k = 0; k < 14; k++)
			send_word($urandom, 3'd4, 1'b0);
		send_word($urandom, 3'd0, 1'b1);

		while (sent < WORD_TARGET) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				send_message($urandom_range(1, 8), 1'b1);
			else if (pick < 19)
				send_message($urandom_range(13, 17), pick == 18);
			else
				send_message($urandom_range(30, 40), 1'b1);
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);

		$display("Sent %0d words in %0d messages; %0d digests checked over %0d cycles.",
			words_in, messages_done, messages_done, cycles);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
